// ===== hw/rtl/vmdoa_pkg.sv =====
package vmdoa_pkg;

	localparam int VmBits  = 32;
	localparam int GenBits = 32;

	localparam logic [15:0] RejectCodeReset = 16'h014F;
	localparam logic [15:0] ModeText80      = 16'h0003;
	localparam logic [15:0] ModeText80Keep  = 16'h0083;

	// Event kinds.
	localparam logic [4:0] OP_DEV_READY      = 5'd0;
	localparam logic [4:0] OP_DEV_REGISTERED = 5'd1;
	localparam logic [4:0] OP_PRE_FG         = 5'd2;
	localparam logic [4:0] OP_POST_FG        = 5'd3;
	localparam logic [4:0] OP_PRE_DESK       = 5'd4;
	localparam logic [4:0] OP_POST_DESK      = 5'd5;
	localparam logic [4:0] OP_DESK_PROG      = 5'd6;
	localparam logic [4:0] OP_DESK_PROG_FAIL = 5'd7;
	localparam logic [4:0] OP_EXCL_BEGIN     = 5'd8;
	localparam logic [4:0] OP_EXCL_END       = 5'd9;
	localparam logic [4:0] OP_DRV_DISABLING  = 5'd10;
	localparam logic [4:0] OP_DEV_EXIT       = 5'd11;
	localparam logic [4:0] OP_SYS_EXIT       = 5'd12;
	localparam logic [4:0] OP_BIOS_MODE      = 5'd13;
	localparam logic [4:0] OP_VBE_MODE       = 5'd14;
	localparam logic [4:0] OP_REG_ACCESS     = 5'd15;
	localparam logic [4:0] OP_OWNER_REPORT   = 5'd16;

	typedef enum logic [4:0] {
		LC_COLD      = 5'b00001,
		LC_READY     = 5'b00010,
		LC_REG       = 5'b00100,
		LC_DISABLING = 5'b01000,
		LC_EXITED    = 5'b10000
	} lifecycle_t;

	localparam logic [1:0] AU_FIRMWARE = 2'd0;
	localparam logic [1:0] AU_DESKTOP  = 2'd1;
	localparam logic [1:0] AU_FGVGA    = 2'd2;

	localparam logic [1:0] TR_NONE    = 2'd0;
	localparam logic [1:0] TR_RECONF  = 2'd1;
	localparam logic [1:0] TR_TO_FG   = 2'd2;
	localparam logic [1:0] TR_TO_DESK = 2'd3;

	localparam logic [1:0] ACT_FORWARD = 2'd0;
	localparam logic [1:0] ACT_CONSUME = 2'd1;
	localparam logic [1:0] ACT_REJECT  = 2'd2;

	typedef struct packed {
		lifecycle_t         lc;
		logic [1:0]         au;
		logic [VmBits-1:0]  au_vm;
		logic [1:0]         tr;
		logic [VmBits-1:0]  tr_vm;
		logic [VmBits-1:0]  desk_vm;
		logic [GenBits-1:0] gen;
	} arb_state_t;

	typedef struct packed {
		logic [4:0]        op;
		logic [VmBits-1:0] vm_id;
		logic [15:0]       mode_value;
		logic              owner_fresh;
		logic [VmBits-1:0] observed_owner;
	} event_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        reject_ax;
		logic               trap_registers;
		logic               seq_fault;
		logic [1:0]         owner_kind;
		logic [VmBits-1:0]  owner_vm;
		logic [GenBits-1:0] owner_generation;
	} result_t;

endpackage

// ===== hw/rtl/vmdoa_if.sv =====
interface vmdoa_in_if;
	logic                          valid;
	logic                          ready;
	logic [4:0]                    op;
	logic [vmdoa_pkg::VmBits-1:0]  vm_id;
	logic [15:0]                   mode_value;
	logic                          owner_fresh;
	logic [vmdoa_pkg::VmBits-1:0]  observed_owner;

	modport source (output valid, op, vm_id, mode_value, owner_fresh, observed_owner,
		input ready);
	modport sink (input valid, op, vm_id, mode_value, owner_fresh, observed_owner,
		output ready);
endinterface

interface vmdoa_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [15:0]                   reject_ax;
	logic                          trap_registers;
	logic                          seq_fault;
	logic [1:0]                    owner_kind;
	logic [vmdoa_pkg::VmBits-1:0]  owner_vm;
	logic [vmdoa_pkg::GenBits-1:0] owner_generation;

	modport source (output valid, action, reject_ax, trap_registers, seq_fault,
		owner_kind, owner_vm, owner_generation, input ready);
	modport sink (input valid, action, reject_ax, trap_registers, seq_fault,
		owner_kind, owner_vm, owner_generation, output ready);
endinterface

// ===== hw/rtl/vmdoa_decide.sv =====
module vmdoa_decide (
	input  vmdoa_pkg::arb_state_t st,
	input  vmdoa_pkg::event_t     ev,
	input  logic [15:0]           reject_code,
	output vmdoa_pkg::arb_state_t nx,
	output vmdoa_pkg::result_t    res
);

	// Post-transition commit check: returns {commit, fault}.
	function automatic logic [1:0] post_eval(
		input vmdoa_pkg::arb_state_t s,
		input logic fresh,
		input logic [vmdoa_pkg::VmBits-1:0] seen,
		input logic [1:0] exp_tr,
		input logic [1:0] want_au,
		input logic [vmdoa_pkg::VmBits-1:0] want_vm
	);
		logic [1:0] r;
		r = 2'b00;
		if (fresh && seen != want_vm) begin
			r = 2'b01;
		end else if (s.tr == vmdoa_pkg::TR_NONE && s.au == want_au && s.au_vm == want_vm) begin
			r = 2'b00;
		end else if ((s.tr == exp_tr && s.tr_vm == want_vm) || fresh) begin
			r = 2'b10;
		end else begin
			r = 2'b01;
		end
		return r;
	endfunction

	logic                          reg_lc;
	logic                          is_desk;
	logic                          vm_nz;
	logic                          fault;
	logic                          deny;
	logic                          do_pend;
	logic [1:0]                    pend_tr;
	logic [vmdoa_pkg::VmBits-1:0]  pend_vm;
	logic                          do_commit;
	logic [1:0]                    cm_au;
	logic [vmdoa_pkg::VmBits-1:0]  cm_vm;
	logic [1:0]                    post_r;
	logic                          req_ok;
	logic                          changed;
	vmdoa_pkg::arb_state_t         mid;

	assign reg_lc  = st.lc == vmdoa_pkg::LC_REG;
	assign vm_nz   = ev.vm_id != '0;
	assign is_desk = vm_nz && ev.vm_id == st.desk_vm;

	always_comb begin
		mid       = st;
		fault     = 1'b0;
		deny      = 1'b0;
		do_pend   = 1'b0;
		pend_tr   = vmdoa_pkg::TR_NONE;
		pend_vm   = '0;
		do_commit = 1'b0;
		cm_au     = vmdoa_pkg::AU_FIRMWARE;
		cm_vm     = '0;
		post_r    = 2'b00;
		req_ok    = 1'b0;

		case (ev.op)
			vmdoa_pkg::OP_DEV_READY: begin
				if (st.lc == vmdoa_pkg::LC_COLD) mid.lc = vmdoa_pkg::LC_READY;
				else if (st.lc != vmdoa_pkg::LC_READY) fault = 1'b1;
			end
			vmdoa_pkg::OP_DEV_REGISTERED: begin
				if (st.lc == vmdoa_pkg::LC_READY && vm_nz) begin
					mid.lc      = vmdoa_pkg::LC_REG;
					mid.desk_vm = ev.vm_id;
					do_pend     = 1'b1;
					pend_tr     = vmdoa_pkg::TR_RECONF;
					pend_vm     = ev.vm_id;
				end else if (st.lc == vmdoa_pkg::LC_DISABLING && is_desk) begin
					mid.lc  = vmdoa_pkg::LC_REG;
					do_pend = 1'b1;
					pend_tr = vmdoa_pkg::TR_RECONF;
					pend_vm = st.desk_vm;
				end else if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_PRE_FG: begin
				if (!reg_lc || !vm_nz) begin
					fault = 1'b1;
				end else if (st.tr == vmdoa_pkg::TR_NONE ||
						(st.tr == vmdoa_pkg::TR_RECONF && st.tr_vm == ev.vm_id)) begin
					do_pend = 1'b1;
					pend_tr = vmdoa_pkg::TR_TO_FG;
					pend_vm = ev.vm_id;
				end else if (st.tr != vmdoa_pkg::TR_TO_FG || st.tr_vm != ev.vm_id) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_POST_FG: begin
				if (!reg_lc || !vm_nz) begin
					fault = 1'b1;
				end else begin
					post_r    = post_eval(st, ev.owner_fresh, ev.observed_owner,
						vmdoa_pkg::TR_TO_FG, vmdoa_pkg::AU_FGVGA, ev.vm_id);
					do_commit = post_r[1];
					fault     = post_r[0];
					cm_au     = vmdoa_pkg::AU_FGVGA;
					cm_vm     = ev.vm_id;
				end
			end
			vmdoa_pkg::OP_PRE_DESK: begin
				if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else if (st.tr == vmdoa_pkg::TR_NONE ||
						(st.tr == vmdoa_pkg::TR_RECONF && st.tr_vm == st.desk_vm)) begin
					do_pend = 1'b1;
					pend_tr = vmdoa_pkg::TR_TO_DESK;
					pend_vm = st.desk_vm;
				end else if (st.tr != vmdoa_pkg::TR_TO_DESK || st.tr_vm != st.desk_vm) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_POST_DESK: begin
				if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else begin
					post_r    = post_eval(st, ev.owner_fresh, ev.observed_owner,
						vmdoa_pkg::TR_TO_DESK, vmdoa_pkg::AU_DESKTOP, st.desk_vm);
					do_commit = post_r[1];
					fault     = post_r[0];
					cm_au     = vmdoa_pkg::AU_DESKTOP;
					cm_vm     = st.desk_vm;
				end
			end
			vmdoa_pkg::OP_DESK_PROG: begin
				if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else if (st.tr == vmdoa_pkg::TR_RECONF && st.tr_vm == st.desk_vm) begin
					do_commit = 1'b1;
					cm_au     = vmdoa_pkg::AU_DESKTOP;
					cm_vm     = st.desk_vm;
				end else if (st.tr == vmdoa_pkg::TR_TO_DESK && st.tr_vm == st.desk_vm) begin
					fault = 1'b0;
				end else if (st.tr != vmdoa_pkg::TR_NONE || st.au != vmdoa_pkg::AU_DESKTOP ||
						st.au_vm != st.desk_vm) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_DESK_PROG_FAIL: begin
				if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else if (st.tr == vmdoa_pkg::TR_NONE) begin
					fault = 1'b0;
				end else if ((st.tr == vmdoa_pkg::TR_RECONF || st.tr == vmdoa_pkg::TR_TO_DESK)
						&& st.tr_vm == st.desk_vm) begin
					do_pend = 1'b1;
				end else begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_EXCL_BEGIN: begin
				if (st.lc == vmdoa_pkg::LC_DISABLING || st.lc == vmdoa_pkg::LC_EXITED) begin
					fault = 1'b0;
				end else if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else if (st.tr != vmdoa_pkg::TR_NONE) begin
					fault = st.tr_vm != st.desk_vm;
				end else if (st.au == vmdoa_pkg::AU_DESKTOP && st.au_vm == st.desk_vm) begin
					do_pend = 1'b1;
					pend_tr = vmdoa_pkg::TR_RECONF;
					pend_vm = st.desk_vm;
				end else if (!(st.au == vmdoa_pkg::AU_FGVGA && st.au_vm == st.desk_vm)) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_EXCL_END: begin
				if (st.lc == vmdoa_pkg::LC_DISABLING || st.lc == vmdoa_pkg::LC_EXITED) begin
					fault = 1'b0;
				end else if (!reg_lc || !is_desk) begin
					fault = 1'b1;
				end else if (st.tr != vmdoa_pkg::TR_NONE) begin
					if (st.tr_vm != st.desk_vm) begin
						fault = 1'b1;
					end else if (st.tr == vmdoa_pkg::TR_RECONF) begin
						if (st.au == vmdoa_pkg::AU_DESKTOP && st.au_vm == st.desk_vm)
							do_pend = 1'b1;
						else if (st.au != vmdoa_pkg::AU_FGVGA)
							fault = 1'b1;
					end
				end else if (st.au == vmdoa_pkg::AU_FGVGA && st.au_vm == st.desk_vm) begin
					do_pend = 1'b1;
					pend_tr = vmdoa_pkg::TR_RECONF;
					pend_vm = st.desk_vm;
				end else if (st.au != vmdoa_pkg::AU_DESKTOP || st.au_vm != st.desk_vm) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_DRV_DISABLING: begin
				if (st.lc == vmdoa_pkg::LC_EXITED) begin
					fault = 1'b0;
				end else if (reg_lc && is_desk) begin
					mid.lc  = vmdoa_pkg::LC_DISABLING;
					do_pend = 1'b1;
				end else if (st.lc != vmdoa_pkg::LC_DISABLING || !is_desk) begin
					fault = 1'b1;
				end
			end
			vmdoa_pkg::OP_DEV_EXIT, vmdoa_pkg::OP_SYS_EXIT: begin
				if (st.lc != vmdoa_pkg::LC_EXITED) begin
					mid.lc      = vmdoa_pkg::LC_EXITED;
					mid.desk_vm = '0;
					do_commit   = 1'b1;
				end
			end
			vmdoa_pkg::OP_BIOS_MODE, vmdoa_pkg::OP_VBE_MODE, vmdoa_pkg::OP_REG_ACCESS: begin
				if (st.lc == vmdoa_pkg::LC_DISABLING) begin
					// While disabling, register accesses and the desktop's BIOS return to text mode pass.
					if (ev.op == vmdoa_pkg::OP_REG_ACCESS) begin
						deny = 1'b0;
					end else if (ev.op == vmdoa_pkg::OP_BIOS_MODE && ev.vm_id == st.desk_vm &&
							(ev.mode_value == vmdoa_pkg::ModeText80 ||
							 ev.mode_value == vmdoa_pkg::ModeText80Keep)) begin
						deny = 1'b0;
					end else begin
						deny = 1'b1;
					end
				end else if (reg_lc) begin
					if (st.tr != vmdoa_pkg::TR_NONE)
						req_ok = vm_nz && ev.vm_id == st.tr_vm;
					else if (st.au == vmdoa_pkg::AU_FGVGA)
						req_ok = vm_nz && ev.vm_id == st.au_vm;
					else
						req_ok = 1'b0;
					deny = !req_ok;
				end
			end
			vmdoa_pkg::OP_OWNER_REPORT: begin
				if (!reg_lc) begin
					fault = 1'b1;
				end else if (!ev.owner_fresh) begin
					fault = 1'b0;
				end else if (!vm_nz || ev.vm_id != ev.observed_owner) begin
					fault = 1'b1;
				end else if (st.tr != vmdoa_pkg::TR_NONE && ev.vm_id != st.tr_vm) begin
					fault = 1'b0;
				end else if (ev.vm_id != st.desk_vm) begin
					do_commit = 1'b1;
					cm_au     = vmdoa_pkg::AU_FGVGA;
					cm_vm     = ev.vm_id;
				end
			end
			default: begin
				fault = 1'b1;
			end
		endcase
	end

	assign changed = st.au != cm_au || st.au_vm != cm_vm || st.tr != vmdoa_pkg::TR_NONE;

	always_comb begin
		nx = mid;
		if (do_pend) begin
			nx.tr    = pend_tr;
			nx.tr_vm = pend_vm;
		end
		if (do_commit) begin
			nx.au    = cm_au;
			nx.au_vm = cm_vm;
			nx.tr    = vmdoa_pkg::TR_NONE;
			nx.tr_vm = '0;
			if (changed) nx.gen = st.gen + vmdoa_pkg::GenBits'(1);
		end
	end

	always_comb begin
		res.action    = vmdoa_pkg::ACT_FORWARD;
		res.reject_ax = '0;
		if (deny) begin
			if (ev.op == vmdoa_pkg::OP_VBE_MODE) begin
				res.action    = vmdoa_pkg::ACT_REJECT;
				res.reject_ax = reject_code;
			end else begin
				res.action = vmdoa_pkg::ACT_CONSUME;
			end
		end
		res.trap_registers   = nx.lc == vmdoa_pkg::LC_REG;
		res.seq_fault        = fault;
		res.owner_kind       = nx.au;
		res.owner_vm         = nx.au_vm;
		res.owner_generation = nx.gen;
	end

endmodule

// ===== hw/rtl/vm_display_ownership_arbiter.sv =====
// Display ownership arbiter.
// in_ch carries one event word per handshake (op, vm_id, mode_value, owner_fresh,
// observed_owner); out_ch returns exactly one result word per event, in order.
// cfg_we/cfg_wdata write the VBE reject code; write it only while the block is idle.
// An event is registered on acceptance, then decided combinationally against the
// arbitration state and written to the output register together with the new state.
// Throughput is one event per cycle while the receiver keeps taking results: the
// input register refills in the same cycle its word moves to the output register,
// and the state update loop through the decision logic adds no limit of its own.
// When the receiver stalls, the output register holds its word, the input register
// holds the next event and in_ch.ready drops until the output drains.
// Reset puts the lifecycle in cold, authority in firmware with no owner and no
// pending transition, zeroes the desktop VM and generation, restores the reject
// code to 0x014F and empties both registers.
module vm_display_ownership_arbiter (
	input  logic              clk,
	input  logic              arst_n,
	vmdoa_in_if.sink          in_ch,
	vmdoa_out_if.source       out_ch,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);

	logic                  valid_s1;
	vmdoa_pkg::event_t     ev_s1;
	logic                  valid_s2;
	vmdoa_pkg::result_t    res_s2;
	logic [15:0]           reject_code_q;
	vmdoa_pkg::arb_state_t state_q;
	vmdoa_pkg::arb_state_t state_nx;
	vmdoa_pkg::result_t    res_nx;
	logic                  advance;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_code_q <= vmdoa_pkg::RejectCodeReset;
		end else if (cfg_we) begin
			reject_code_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			ev_s1.op             <= in_ch.op;
			ev_s1.vm_id          <= in_ch.vm_id;
			ev_s1.mode_value     <= in_ch.mode_value;
			ev_s1.owner_fresh    <= in_ch.owner_fresh;
			ev_s1.observed_owner <= in_ch.observed_owner;
		end
	end

	vmdoa_decide u_decide (
		.st          (state_q),
		.ev          (ev_s1),
		.reject_code (reject_code_q),
		.nx          (state_nx),
		.res         (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lc      <= vmdoa_pkg::LC_COLD;
			state_q.au      <= vmdoa_pkg::AU_FIRMWARE;
			state_q.au_vm   <= '0;
			state_q.tr      <= vmdoa_pkg::TR_NONE;
			state_q.tr_vm   <= '0;
			state_q.desk_vm <= '0;
			state_q.gen     <= '0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.action           = res_s2.action;
	assign out_ch.reject_ax        = res_s2.reject_ax;
	assign out_ch.trap_registers   = res_s2.trap_registers;
	assign out_ch.seq_fault        = res_s2.seq_fault;
	assign out_ch.owner_kind       = res_s2.owner_kind;
	assign out_ch.owner_vm         = res_s2.owner_vm;
	assign out_ch.owner_generation = res_s2.owner_generation;

endmodule
